[design/can_signal_extract_and_change_detect_unit_assert.svh]
// assertion helpers used by the checker file
`ifndef CAN_SIGNAL_EXTRACT_AND_CHANGE_DETECT_UNIT_ASSERT_SVH
`define CAN_SIGNAL_EXTRACT_AND_CHANGE_DETECT_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define CSCD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define CSCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/cscd_pkg.sv]
package cscd_pkg;

	// frame geometry
	localparam int FRAME_BYTES   = 8;
	localparam int DATA_W        = 64;
	localparam int LEN_W         = 4;

	// fixed point
	localparam int FRACTION_BITS = 16;
	localparam int VALUE_W       = 48;
	localparam int SCALE_W       = 32;
	localparam int RAW_W         = 25;
	localparam int PROD_W        = RAW_W + SCALE_W;
	localparam int SUM_W         = PROD_W + 1;
	localparam int DIFF_W        = VALUE_W + 2;
	localparam longint CHANGE_THRESHOLD = (64'sd1 <<< FRACTION_BITS) / 100;

	// configuration port
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 48;

	localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_FORMAT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_BYTE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_POSITION  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_LENGTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_VALUE  = 3'd5;

	// signal formats
	localparam logic [3:0] FMT_U8     = 4'd0;
	localparam logic [3:0] FMT_BOOL   = 4'd1;
	localparam logic [3:0] FMT_U7     = 4'd2;
	localparam logic [3:0] FMT_U3     = 4'd3;
	localparam logic [3:0] FMT_U4     = 4'd4;
	localparam logic [3:0] FMT_U16BE  = 4'd5;
	localparam logic [3:0] FMT_S16BE  = 4'd6;
	localparam logic [3:0] FMT_U16LE  = 4'd7;
	localparam logic [3:0] FMT_S16LE  = 4'd8;
	localparam logic [3:0] FMT_U24BE  = 4'd9;
	localparam logic [3:0] FMT_U12BE  = 4'd10;
	localparam logic [3:0] FMT_S12BE  = 4'd11;
	localparam logic [3:0] FMT_U12LOW = 4'd12;
	localparam logic [3:0] FMT_U11BE  = 4'd13;
	localparam logic [3:0] FMT_U10BE  = 4'd14;
	localparam logic [3:0] FMT_LEGACY = 4'd15;

	// reset values and legacy field lengths
	localparam logic [3:0] BIT_POS_BYTE_MODE = 4'd8;
	localparam logic [4:0] FIELD_LEN_RESET   = 5'd8;
	localparam logic [4:0] LEGACY_LEN_BYTE   = 5'd8;
	localparam logic [4:0] LEGACY_LEN_TEN    = 5'd10;
	localparam logic signed [SCALE_W-1:0] SCALE_RESET = 32'sd65536;

	typedef struct packed {
		logic [3:0]                  signal_format;
		logic [2:0]                  first_byte;
		logic [3:0]                  bit_position;
		logic [4:0]                  field_length;
		logic signed [SCALE_W-1:0]   scale_factor;
		logic signed [VALUE_W-1:0]   offset_value;
	} cfg_t;

	typedef struct packed {
		logic load_s1;
		logic adv_s2;
		logic adv_s3;
		logic adv_out;
	} pipe_ctl_t;

endpackage

[design/cscd_cfg_regs.sv]
module cscd_cfg_regs import cscd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.signal_format <= FMT_U8;
			cfg_q.first_byte    <= 3'd0;
			cfg_q.bit_position  <= BIT_POS_BYTE_MODE;
			cfg_q.field_length  <= FIELD_LEN_RESET;
			cfg_q.scale_factor  <= SCALE_RESET;
			cfg_q.offset_value  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_SIGNAL_FORMAT: cfg_q.signal_format <= wr_data[3:0];
				REG_FIRST_BYTE:    cfg_q.first_byte    <= wr_data[2:0];
				REG_BIT_POSITION:  cfg_q.bit_position  <= wr_data[3:0];
				REG_FIELD_LENGTH:  cfg_q.field_length  <= wr_data[4:0];
				REG_SCALE_FACTOR:  cfg_q.scale_factor  <= wr_data[SCALE_W-1:0];
				REG_OFFSET_VALUE:  cfg_q.offset_value  <= wr_data[VALUE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/cscd_extract.sv]
module cscd_extract import cscd_pkg::*; #(
	parameter int FRAME_BYTES = cscd_pkg::FRAME_BYTES
) (
	input  logic                    clk,
	input  pipe_ctl_t               ctl,
	input  cfg_t                    cfg,
	input  logic [DATA_W-1:0]       frame_data,
	input  logic [LEN_W-1:0]        frame_length,
	output logic signed [RAW_W-1:0] raw,
	output logic                    raw_ok
);

	logic [DATA_W-1:0] data_s1;
	logic [LEN_W-1:0]  len_s1;

	logic [3:0] idx0, idx1, idx2;
	logic [7:0] b0, b1, b2;
	logic       p1, p2, p3;
	logic [2:0] bp;
	logic [3:0] first_bits;
	logic [4:0] second;
	logic [3:0] second_c;
	logic [7:0] b0_sh;
	logic [RAW_W-1:0] raw_v;
	logic       got;

	// input register
	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			data_s1 <= frame_data;
			len_s1  <= frame_length;
		end
	end

	// bytes past the payload word read as zero
	function automatic logic [7:0] byte_at(logic [DATA_W-1:0] d, logic [3:0] i);
		if (i[3])
			return 8'd0;
		return d[{i[2:0], 3'b000} +: 8];
	endfunction

	function automatic logic byte_ok(logic [3:0] i, logic [LEN_W-1:0] len);
		return (i < len) && ({28'd0, i} < 32'(FRAME_BYTES));
	endfunction

	// low k bits set, k up to 8
	function automatic logic [7:0] low_mask(logic [3:0] k);
		return 8'((9'd1 << k) - 9'd1);
	endfunction

	always_comb begin
		idx0       = {1'b0, cfg.first_byte};
		idx1       = idx0 + 4'd1;
		idx2       = idx0 + 4'd2;
		b0         = byte_at(data_s1, idx0);
		b1         = byte_at(data_s1, idx1);
		b2         = byte_at(data_s1, idx2);
		p1         = byte_ok(idx0, len_s1);
		p2         = p1 && byte_ok(idx1, len_s1);
		p3         = p2 && byte_ok(idx2, len_s1);
		bp         = cfg.bit_position[2:0];
		first_bits = 4'd8 - {1'b0, bp};
		b0_sh      = b0 >> bp;
		second     = cfg.field_length - {1'b0, first_bits};
		second_c   = (second > 5'd8) ? 4'd8 : second[3:0];
		raw_v      = '0;
		got        = 1'b0;

		if (!cfg.bit_position[3]) begin
			// bit field
			if (cfg.field_length <= {1'b0, first_bits}) begin
				got   = p1;
				raw_v = {17'd0, b0_sh & low_mask(cfg.field_length[3:0])};
			end else begin
				got   = p2;
				raw_v = {9'd0, ({8'd0, b1 & low_mask(second_c)} << first_bits)
					| {8'd0, b0_sh}};
			end
		end else begin
			case (cfg.signal_format)
				FMT_U8, FMT_BOOL: begin
					got = p1; raw_v = {17'd0, b0};
				end
				FMT_U7: begin
					got = p1; raw_v = {17'd0, b0 & 8'h7F};
				end
				FMT_U3: begin
					got = p1; raw_v = {17'd0, b0 & 8'h07};
				end
				FMT_U4: begin
					got = p1; raw_v = {17'd0, b0 & 8'h0F};
				end
				FMT_U16BE: begin
					got = p2; raw_v = {9'd0, b0, b1};
				end
				FMT_S16BE: begin
					got = p2; raw_v = {{9{b0[7]}}, b0, b1};
				end
				FMT_U16LE: begin
					got = p2; raw_v = {9'd0, b1, b0};
				end
				FMT_S16LE: begin
					got = p2; raw_v = {{9{b1[7]}}, b1, b0};
				end
				FMT_U24BE: begin
					got = p3; raw_v = {1'b0, b0, b1, b2};
				end
				FMT_U12BE: begin
					got = p2; raw_v = {13'd0, b0, b1[7:4]};
				end
				FMT_S12BE: begin
					got = p2; raw_v = {{13{b0[7]}}, b0, b1[7:4]};
				end
				FMT_U12LOW: begin
					got = p2; raw_v = {13'd0, b0[3:0], b1};
				end
				FMT_U11BE: begin
					got = p2; raw_v = {14'd0, b0, b1[7:5]};
				end
				FMT_U10BE: begin
					got = p2; raw_v = {15'd0, b0, b1[7:6]};
				end
				default: begin
					// legacy: one byte or ten bit big-endian, else nothing
					if (cfg.field_length == LEGACY_LEN_BYTE) begin
						got = p1; raw_v = {17'd0, b0};
					end else if (cfg.field_length == LEGACY_LEN_TEN) begin
						got = p2; raw_v = {15'd0, b0, b1[7:6]};
					end
				end
			endcase
		end

		if (!got)
			raw_v = '0;
	end

	assign raw    = raw_v;
	assign raw_ok = got;

endmodule

[design/cscd_scale.sv]
module cscd_scale import cscd_pkg::*; (
	input  logic                      clk,
	input  pipe_ctl_t                 ctl,
	input  cfg_t                      cfg,
	input  logic signed [RAW_W-1:0]   raw,
	input  logic                      raw_ok,
	output logic signed [VALUE_W-1:0] value,
	output logic                      value_ok
);

	logic signed [PROD_W-1:0]  prod_s2;
	logic                      ok_s2;
	logic signed [VALUE_W-1:0] value_s3;
	logic                      ok_s3;

	logic signed [SUM_W-1:0]   sum;
	logic                      fits;
	logic signed [VALUE_W-1:0] sat;

	// raw times scale
	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			prod_s2 <= PROD_W'(raw) * PROD_W'(cfg.scale_factor);
			ok_s2   <= raw_ok;
		end
	end

	// add offset, clamp to the 48 bit range
	always_comb begin
		sum  = SUM_W'(prod_s2) + SUM_W'(cfg.offset_value);
		fits = (sum[SUM_W-1:VALUE_W-1] == '0) || (sum[SUM_W-1:VALUE_W-1] == '1);
		if (fits)
			sat = sum[VALUE_W-1:0];
		else if (sum[SUM_W-1])
			sat = {1'b1, {(VALUE_W-1){1'b0}}};
		else
			sat = {1'b0, {(VALUE_W-1){1'b1}}};
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s3) begin
			value_s3 <= sat;
			ok_s3    <= ok_s2;
		end
	end

	assign value    = value_s3;
	assign value_ok = ok_s3;

endmodule

[design/cscd_change.sv]
module cscd_change import cscd_pkg::*; #(
	parameter int FRACTION_BITS = cscd_pkg::FRACTION_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pipe_ctl_t                 ctl,
	input  cfg_t                      cfg,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      value_ok,
	output logic signed [VALUE_W-1:0] signal_value,
	output logic                      bytes_present,
	output logic                      value_changed
);

	// one hundredth of unity in the value's fixed point
	localparam logic signed [DIFF_W-1:0] THR_POS = DIFF_W'((64'sd1 <<< FRACTION_BITS) / 100);
	localparam logic signed [DIFF_W-1:0] THR_NEG = -THR_POS;

	logic                      have_q;
	logic signed [VALUE_W-1:0] value_q;
	logic                      present_q;
	logic                      changed_q;

	logic signed [DIFF_W-1:0]  diff;
	logic                      changed;

	// the output register doubles as the previous value
	always_comb begin
		diff = DIFF_W'(value) - DIFF_W'(value_q);
		if (!have_q)
			changed = 1'b1;
		else if (cfg.signal_format == FMT_BOOL)
			changed = (value_q != '0) != (value != '0);
		else
			changed = (diff > THR_POS) || (diff < THR_NEG);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			have_q <= 1'b0;
		else if (ctl.adv_out)
			have_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_out) begin
			value_q   <= value;
			present_q <= value_ok;
			changed_q <= changed;
		end
	end

	assign signal_value  = value_q;
	assign bytes_present = present_q;
	assign value_changed = changed_q;

endmodule

[design/can_signal_extract_and_change_detect_unit.sv]
// CAN signal extractor with change detection. Each input transaction carries one payload of
// eight bytes (byte 0 in bits 7..0) and its length code; each yields exactly one output
// transaction with the extracted signal scaled as raw * scale_factor + offset_value in signed
// Q31.16, clamped to 48 bits, a flag telling whether every byte the signal needs was inside
// the frame, and a flag telling whether the value moved by more than 0.01 (zero versus
// nonzero for the bool format) since the previous frame; the first frame after reset is
// always flagged. The block takes one frame per clock unless a stalled output has backed up
// the pipeline, and delivers it through a four register pipeline: input register, multiplier register,
// offset and clamp register, then the output register, which also holds the previous
// value for the change compare. A stalled output backs up the pipeline one stage at a
// time, so input is taken while results wait. Configuration writes are always ready and
// must only be issued while no frame is in flight.
module can_signal_extract_and_change_detect_unit import cscd_pkg::*; #(
	parameter int FRAME_BYTES   = cscd_pkg::FRAME_BYTES,
	parameter int FRACTION_BITS = cscd_pkg::FRACTION_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,

	// configuration write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,

	// frame input
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [DATA_W-1:0]         frame_data,
	input  logic [LEN_W-1:0]          frame_length,

	// result output
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] signal_value,
	output logic                      bytes_present,
	output logic                      value_changed
);

	cfg_t      cfg;
	pipe_ctl_t ctl;

	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic free_s1, free_s2, free_s3;
	logic accept;

	logic signed [RAW_W-1:0]   raw;
	logic                      raw_ok;
	logic signed [VALUE_W-1:0] value;
	logic                      value_ok;

	// register file takes a write every cycle
	assign cfg_ready = 1'b1;

	cscd_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// per-stage advance: a stage moves when the one ahead is empty or moving
	always_comb begin
		ctl.adv_out = valid_s3 && (!out_valid_q || !out_stall);
		free_s3     = !valid_s3 || ctl.adv_out;
		ctl.adv_s3  = valid_s2 && free_s3;
		free_s2     = !valid_s2 || ctl.adv_s3;
		ctl.adv_s2  = valid_s1 && free_s2;
		free_s1     = !valid_s1 || ctl.adv_s2;
		accept      = in_valid && free_s1;
		ctl.load_s1 = accept;
	end

	assign in_stall  = !free_s1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.load_s1)
				valid_s1 <= 1'b1;
			else if (ctl.adv_s2)
				valid_s1 <= 1'b0;

			if (ctl.adv_s2)
				valid_s2 <= 1'b1;
			else if (ctl.adv_s3)
				valid_s2 <= 1'b0;

			if (ctl.adv_s3)
				valid_s3 <= 1'b1;
			else if (ctl.adv_out)
				valid_s3 <= 1'b0;

			// output holds until the transaction completes
			if (ctl.adv_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// input register and byte selection
	cscd_extract #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_extract (
		.clk          (clk),
		.ctl          (ctl),
		.cfg          (cfg),
		.frame_data   (frame_data),
		.frame_length (frame_length),
		.raw          (raw),
		.raw_ok       (raw_ok)
	);

	// multiply, then offset and clamp
	cscd_scale u_scale (
		.clk      (clk),
		.ctl      (ctl),
		.cfg      (cfg),
		.raw      (raw),
		.raw_ok   (raw_ok),
		.value    (value),
		.value_ok (value_ok)
	);

	// change compare against the last delivered value, output register
	cscd_change #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_change (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.cfg           (cfg),
		.value         (value),
		.value_ok      (value_ok),
		.signal_value  (signal_value),
		.bytes_present (bytes_present),
		.value_changed (value_changed)
	);

endmodule

[design/cscd_checker.sv]
`include "can_signal_extract_and_change_detect_unit_assert.svh"

module cscd_checker import cscd_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic signed [VALUE_W-1:0] signal_value,
	input logic                      bytes_present,
	input logic                      value_changed
);

	logic                      seen_q;
	logic signed [VALUE_W-1:0] last_q;
	logic [VALUE_W+1:0]        result_bits;
	logic                      out_held;
	logic                      first_out;
	logic                      same_out;

	assign result_bits = {signal_value, bytes_present, value_changed};
	assign out_held    = out_valid && out_stall;
	assign first_out   = out_valid && !seen_q;
	assign same_out    = out_valid && seen_q && (signal_value == last_q);

	// track the last delivered value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seen_q <= 1'b0;
		else if (out_valid && !out_stall)
			seen_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (out_valid && !out_stall)
			last_q <= signal_value;
	end

	`CSCD_ASSERT_NEXT(a_out_valid_hold, out_held, out_valid, "result dropped while stalled")
	`CSCD_ASSERT_NEXT(a_out_payload_hold, out_held, $stable(result_bits), "stalled result moved")
	`CSCD_ASSERT_NOW(a_first_flagged, first_out, value_changed, "first result not flagged")
	`CSCD_ASSERT_NOW(a_repeat_not_flagged, same_out, !value_changed, "unchanged value flagged")

endmodule

bind can_signal_extract_and_change_detect_unit cscd_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.signal_value  (signal_value),
	.bytes_present (bytes_present),
	.value_changed (value_changed)
);

[dv/can_signal_extract_and_change_detect_unit_tb.sv]
module can_signal_extract_and_change_detect_unit_tb;
	import cscd_pkg::*;

	// run length guards
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 10;
	localparam int LONG_HOLD     = 250;
	localparam int RANDOM_PHASES = 40;
	localparam int PHASE_FRAMES  = 36;
	localparam int PRESSURE_PHASE = 6;
	localparam int PAUSE_PHASE   = 12;

	// signed 48 bit clamp bounds
	localparam longint VALUE_MAX = (longint'(1) <<< (VALUE_W - 1)) - 1;
	localparam longint VALUE_MIN = -(longint'(1) <<< (VALUE_W - 1));

	// one frame as offered on the input channel
	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [LEN_W-1:0]  len;
	} frame_t;

	// one expected output transaction
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      present;
		logic                      changed;
	} signal_result_t;

	// receiver back-pressure styles
	typedef enum int {STALL_NONE, STALL_HEAVY, STALL_LIGHT, STALL_PERIODIC} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// every block input starts at a known value
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [DATA_W-1:0]         frame_data = '0;
	logic [LEN_W-1:0]          frame_length = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [VALUE_W-1:0] signal_value;
	logic                      bytes_present;
	logic                      value_changed;

	can_signal_extract_and_change_detect_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.frame_data   (frame_data),
		.frame_length (frame_length),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.signal_value (signal_value),
		.bytes_present(bytes_present),
		.value_changed(value_changed)
	);

	always #6 clk = ~clk;

	// shadow of the block's registers, starts at the reset values
	cfg_t shadow_cfg = '{signal_format: FMT_U8, first_byte: 3'd0,
		bit_position: BIT_POS_BYTE_MODE, field_length: FIELD_LEN_RESET,
		scale_factor: SCALE_RESET, offset_value: '0};

	// shadow of the change detector state
	longint last_value = 0;
	bit     seen_frame = 1'b0;

	frame_t         pending_frames[$];
	signal_result_t expected_signals[$];

	int  queued_total   = 0;
	int  accepted_count = 0;
	int  result_count   = 0;
	int  changed_count  = 0;
	int  absent_count   = 0;
	int  error_count    = 0;
	int  write_count    = 0;
	int  setting_count  = 0;
	int  cycle_count    = 0;
	bit  frame_taken    = 1'b0;

	// sender burst state
	int burst_left = 0;
	int gap_left   = 0;

	// receiver state
	stall_mode_t stall_mode = STALL_NONE;
	int mode_left       = 0;
	int hold_left       = 0;
	int holds_requested = 0;
	int holds_served    = 0;

	function automatic logic [7:0] payload_byte(input logic [DATA_W-1:0] data, input int unsigned idx);
		if (idx >= 8)
			return 8'd0;
		return data[8*idx +: 8];
	endfunction

	function automatic bit byte_in_frame(input int unsigned idx, input logic [LEN_W-1:0] len);
		return (idx < len) && (idx < FRAME_BYTES);
	endfunction

	// extracts, scales and change-checks one frame against the shadow state
	function automatic signal_result_t predict_signal(input logic [DATA_W-1:0] data,
		input logic [LEN_W-1:0] len);
		int unsigned n, bp, fl, first_bits, second;
		longint b0, b1, b2, raw, val, diff;
		bit p1, p2, p3, got;
		signal_result_t r;
		n  = 32'(shadow_cfg.first_byte);
		bp = 32'(shadow_cfg.bit_position);
		fl = 32'(shadow_cfg.field_length);
		b0 = 64'(payload_byte(data, n));
		b1 = 64'(payload_byte(data, n + 1));
		b2 = 64'(payload_byte(data, n + 2));
		p1 = byte_in_frame(n, len);
		p2 = p1 && byte_in_frame(n + 1, len);
		p3 = p2 && byte_in_frame(n + 2, len);
		raw = 0;
		got = 1'b0;
		if (bp < 8) begin
			// bit field, possibly spilling into the next byte
			first_bits = 8 - bp;
			if (fl <= first_bits) begin
				got = p1;
				raw = (b0 >> bp) & ((longint'(1) << fl) - 1);
			end else begin
				second = fl - first_bits;
				if (second > 8)
					second = 8;
				got = p2;
				raw = ((b0 >> bp) & ((longint'(1) << first_bits) - 1)) |
					((b1 & ((longint'(1) << second) - 1)) << first_bits);
			end
		end else begin
			case (shadow_cfg.signal_format)
				FMT_U8, FMT_BOOL: begin got = p1; raw = b0; end
				FMT_U7: begin got = p1; raw = b0 & 'h7F; end
				FMT_U3: begin got = p1; raw = b0 & 'h07; end
				FMT_U4: begin got = p1; raw = b0 & 'h0F; end
				FMT_U16BE, FMT_S16BE: begin
					got = p2;
					raw = (b0 << 8) | b1;
					if (shadow_cfg.signal_format == FMT_S16BE && raw > 32767)
						raw -= 65536;
				end
				FMT_U16LE, FMT_S16LE: begin
					got = p2;
					raw = b0 | (b1 << 8);
					if (shadow_cfg.signal_format == FMT_S16LE && raw > 32767)
						raw -= 65536;
				end
				FMT_U24BE: begin got = p3; raw = (b0 << 16) | (b1 << 8) | b2; end
				FMT_U12BE, FMT_S12BE: begin
					got = p2;
					raw = (b0 << 4) | (b1 >> 4);
					if (shadow_cfg.signal_format == FMT_S12BE && raw > 2047)
						raw -= 4096;
				end
				FMT_U12LOW: begin got = p2; raw = ((b0 & 'h0F) << 8) | b1; end
				FMT_U11BE: begin got = p2; raw = (b0 << 3) | (b1 >> 5); end
				FMT_U10BE: begin got = p2; raw = (b0 << 2) | (b1 >> 6); end
				FMT_LEGACY: begin
					if (shadow_cfg.field_length == LEGACY_LEN_BYTE) begin
						got = p1;
						raw = b0;
					end else if (shadow_cfg.field_length == LEGACY_LEN_TEN) begin
						got = p2;
						raw = (b0 << 2) | (b1 >> 6);
					end
				end
				default: ;
			endcase
		end
		if (!got)
			raw = 0;
		val = raw * longint'($signed(shadow_cfg.scale_factor)) +
			longint'($signed(shadow_cfg.offset_value));
		if (val > VALUE_MAX)
			val = VALUE_MAX;
		if (val < VALUE_MIN)
			val = VALUE_MIN;
		if (!seen_frame) begin
			r.changed = 1'b1;
		end else if (shadow_cfg.signal_format == FMT_BOOL) begin
			r.changed = (last_value != 0) != (val != 0);
		end else begin
			diff = val - last_value;
			if (diff < 0)
				diff = -diff;
			r.changed = diff > CHANGE_THRESHOLD;
		end
		last_value = val;
		seen_frame = 1'b1;
		r.value = val[VALUE_W-1:0];
		r.present = got;
		return r;
	endfunction

	// run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("can_signal_extract_and_change_detect_unit verification failed");
			$finish;
		end
	end

	// monitor: records accepted frames and checks every output transaction
	always @(posedge clk) begin : monitor
		signal_result_t want;
		if (arst_n) begin
			frame_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				expected_signals.push_back(predict_signal(frame_data, frame_length));
				accepted_count++;
			end
			if (out_valid && !out_stall) begin
				result_count++;
				if (value_changed)
					changed_count++;
				if (!bytes_present)
					absent_count++;
				if (expected_signals.size() == 0) begin
					$error("result transaction with nothing expected: value %0d", signal_value);
					error_count++;
				end else begin
					want = expected_signals.pop_front();
					if (signal_value !== want.value) begin
						$error("signal_value: expected %0d, actual %0d",
							$signed(want.value), signal_value);
						error_count++;
					end
					if (bytes_present !== want.present) begin
						$error("bytes_present: expected %0b, actual %0b",
							want.present, bytes_present);
						error_count++;
					end
					if (value_changed !== want.changed) begin
						$error("value_changed: expected %0b, actual %0b",
							want.changed, value_changed);
						error_count++;
					end
				end
			end
		end
	end

	// driver: offers queued frames in bursts, holds a payload until it is taken
	always @(negedge clk) begin : driver
		frame_t next_frame;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !frame_taken) begin
			// stalled transaction keeps its payload
		end else if (gap_left > 0) begin
			in_valid <= 1'b0;
			gap_left--;
		end else if (pending_frames.size() > 0) begin
			next_frame = pending_frames.pop_front();
			in_valid <= 1'b1;
			frame_data <= next_frame.data;
			frame_length <= next_frame.len;
			if (burst_left <= 1) begin
				burst_left = $urandom_range(1, 24);
				// a quarter of the bursts run back to back with no gap
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left--;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver: back-pressure pattern of its own, plus long holds on request
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 80);
			end else begin
				mode_left--;
			end
			if (holds_served != holds_requested) begin
				holds_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (stall_mode)
					STALL_NONE:     out_stall <= 1'b0;
					STALL_HEAVY:    out_stall <= ($urandom_range(0, 1) == 1);
					STALL_LIGHT:    out_stall <= ($urandom_range(0, 4) == 0);
					STALL_PERIODIC: out_stall <= (mode_left % 3 == 0);
					default:        out_stall <= 1'b0;
				endcase
			end
		end
	end

	// one register write transaction, shadow follows at the handshake
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		write_count++;
		case (idx)
			REG_SIGNAL_FORMAT: shadow_cfg.signal_format = value[3:0];
			REG_FIRST_BYTE:    shadow_cfg.first_byte = value[2:0];
			REG_BIT_POSITION:  shadow_cfg.bit_position = value[3:0];
			REG_FIELD_LENGTH:  shadow_cfg.field_length = value[4:0];
			REG_SCALE_FACTOR:  shadow_cfg.scale_factor = value[SCALE_W-1:0];
			REG_OFFSET_VALUE:  shadow_cfg.offset_value = value[VALUE_W-1:0];
			default: ;
		endcase
	endtask

	// full register setting, only called with the pipeline empty
	task automatic apply_setting(input logic [3:0] fmt, input logic [2:0] fb,
		input logic [3:0] bp, input logic [4:0] fl,
		input logic [SCALE_W-1:0] scale, input logic [VALUE_W-1:0] offset);
		write_reg(REG_SIGNAL_FORMAT, {44'd0, fmt});
		write_reg(REG_FIRST_BYTE, {45'd0, fb});
		write_reg(REG_BIT_POSITION, {44'd0, bp});
		write_reg(REG_FIELD_LENGTH, {43'd0, fl});
		write_reg(REG_SCALE_FACTOR, {16'd0, scale});
		write_reg(REG_OFFSET_VALUE, offset);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		setting_count++;
	endtask

	task automatic queue_frame(input logic [DATA_W-1:0] data, input logic [LEN_W-1:0] len);
		pending_frames.push_back('{data: data, len: len});
		queued_total++;
	endtask

	// waits for every frame to be taken and answered, then lets the pipeline settle
	task automatic drain_pipeline();
		do @(negedge clk); while (accepted_count != queued_total || expected_signals.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// repeats and single bit nudges so change detection sees small deltas, otherwise fresh payloads
	function automatic frame_t next_random_frame(input frame_t prev);
		frame_t f;
		int roll;
		roll = $urandom_range(0, 99);
		f = prev;
		if (roll < 45) begin
			if (roll >= 25)
				f.data[$urandom_range(0, DATA_W - 1)] ^= 1'b1;
		end else begin
			f.data = {$urandom, $urandom};
			f.len = ($urandom_range(0, 9) < 7) ? LEN_W'($urandom_range(8, 15)) :
				LEN_W'($urandom_range(0, 7));
		end
		return f;
	endfunction

	initial begin : stimulus
		logic [3:0]         r_fmt;
		logic [2:0]         r_fb;
		logic [3:0]         r_bp;
		logic [4:0]         r_fl;
		logic [SCALE_W-1:0] r_scale;
		logic [VALUE_W-1:0] r_offset;
		frame_t             f;
		int                 k;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset setting: u8 of byte 0 at unit scale, full, empty and long length codes
		queue_frame({DATA_W{1'b1}}, 4'd8);
		queue_frame({DATA_W{1'b1}}, 4'd0);
		queue_frame({DATA_W{1'b1}}, 4'd0);
		queue_frame(64'h0000_0000_0000_00AB, 4'd15);
		drain_pipeline();

		// every byte-type format once, legacy in its ten bit form
		for (int fmt = 0; fmt < 16; fmt++) begin
			apply_setting(fmt[3:0], 3'd5, BIT_POS_BYTE_MODE, LEGACY_LEN_TEN, SCALE_RESET, '0);
			queue_frame({$urandom, $urandom}, 4'd8);
			drain_pipeline();
		end

		// clamp at both ends of the 48 bit range
		apply_setting(FMT_U24BE, 3'd0, BIT_POS_BYTE_MODE, FIELD_LEN_RESET,
			32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF);
		queue_frame({DATA_W{1'b1}}, 4'd8);
		drain_pipeline();
		apply_setting(FMT_U24BE, 3'd0, BIT_POS_BYTE_MODE, FIELD_LEN_RESET,
			32'h8000_0000, 48'h8000_0000_0000);
		queue_frame({DATA_W{1'b1}}, 4'd8);
		drain_pipeline();

		// overlong bit field spanning into the last byte
		apply_setting(FMT_U8, 3'd6, 4'd3, 5'd31, SCALE_RESET, '0);
		queue_frame({$urandom, $urandom}, 4'd8);
		drain_pipeline();

		// zero length bit field
		apply_setting(FMT_U8, 3'd0, 4'd0, 5'd0, SCALE_RESET, 48'd1000);
		queue_frame({DATA_W{1'b1}}, 4'd8);
		drain_pipeline();

		// bit position above eight falls back to byte-type, second byte lies past the payload
		apply_setting(FMT_S16LE, 3'd7, 4'd12, FIELD_LEN_RESET, SCALE_RESET, '0);
		queue_frame({DATA_W{1'b1}}, 4'd15);
		drain_pipeline();

		// random settings, each followed by a run of frames
		f = '{data: '0, len: 4'd8};
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			r_fmt = 4'($urandom_range(0, 15));
			r_fb = 3'($urandom_range(0, 7));
			k = $urandom_range(0, 9);
			if (k < 5)
				r_bp = 4'($urandom_range(0, 7));
			else if (k < 8)
				r_bp = BIT_POS_BYTE_MODE;
			else
				r_bp = 4'($urandom_range(9, 15));
			k = $urandom_range(0, 9);
			if (r_bp < BIT_POS_BYTE_MODE)
				r_fl = (k == 0) ? 5'd0 : (k == 1) ? 5'($urandom_range(17, 31)) :
					5'($urandom_range(1, 16));
			else if (r_fmt == FMT_LEGACY && k < 8)
				r_fl = (k < 4) ? LEGACY_LEN_BYTE : LEGACY_LEN_TEN;
			else
				r_fl = 5'($urandom_range(0, 31));
			case ($urandom_range(0, 5))
				0: r_scale = SCALE_RESET;
				1: r_scale = $urandom_range(0, 2000);
				2: r_scale = -$urandom_range(1, 70000);
				3: r_scale = $urandom;
				4: r_scale = 32'h7FFF_FFFF;
				default: r_scale = 32'h8000_0000;
			endcase
			case ($urandom_range(0, 4))
				0: r_offset = '0;
				1: r_offset = VALUE_W'(longint'($urandom_range(0, 200000)) - 100000);
				2: r_offset = VALUE_W'({$urandom, $urandom});
				3: r_offset = 48'h7FFF_FFFF_FFFF;
				default: r_offset = 48'h8000_0000_0000;
			endcase
			apply_setting(r_fmt, r_fb, r_bp, r_fl, r_scale, r_offset);

			for (int i = 0; i < PHASE_FRAMES; i++) begin
				f = next_random_frame(f);
				queue_frame(f.data, f.len);
				// sender stops until every result of the first half is back
				if (phase == PAUSE_PHASE && i == PHASE_FRAMES / 2 - 1)
					drain_pipeline();
			end
			// long receiver hold while frames keep coming, fills the pipeline
			if (phase == PRESSURE_PHASE)
				holds_requested++;
			drain_pipeline();
		end

		drain_pipeline();
		if (expected_signals.size() != 0) begin
			$error("%0d expected results never arrived", expected_signals.size());
			error_count++;
		end

		$display("covered %0d frames under %0d register settings (%0d register writes)",
			accepted_count, setting_count, write_count);
		$display("checked %0d results: %0d flagged changed, %0d with bytes missing, %0d errors",
			result_count, changed_count, absent_count, error_count);
		if (error_count == 0) begin
			$display("can_signal_extract_and_change_detect_unit verification clean");
		end else begin
			$display("can_signal_extract_and_change_detect_unit verification failed");
		end
		$finish;
	end

endmodule
